// ===== rtl/core/arcd_pkg.sv =====
// arcd_pkg: shared types, codes and constants of the alignment record decoder
// no dependencies; used by every module in rtl/core
`default_nettype none

package arcd_pkg;

    // queue depths, defaults for the top-level parameters
    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 4;

    // record magic, first byte in the low bits: "ALIGNRLE"
    localparam logic [63:0] MAGIC_WORD = 64'h454C_524E_4749_4C41;

    // result status codes
    localparam logic [1:0] ST_ITEM    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD_MAG = 2'd2;
    localparam logic [1:0] ST_BAD_VER = 2'd3;

    // weight formats
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_U16  = 2'd1;
    localparam logic [1:0] FMT_F32  = 2'd2;

    // weighted-scheme versions
    localparam logic [1:0] VER_PLAIN = 2'd0;
    localparam logic [1:0] VER_U16   = 2'd1;
    localparam logic [1:0] VER_F32   = 2'd2;

    // highest supported weighted-scheme version
    localparam logic [30:0] MAX_VERSION = 31'd2;

    // byte word after classification in the front end
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       zero;
        logic       more;
    } t_byte_item;

    // one result word
    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] emission_id;
        logic [6:0]  run_length;
        logic [31:0] weight_raw;
        logic [1:0]  weight_format;
        logic        last_item;
        logic [1:0]  status;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        return MAGIC_WORD[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/arcd_front.sv =====
// arcd_front: input byte queue; tags each word with start, zero and more flags
// depends on arcd_pkg
`default_nettype none

module arcd_front #(
    parameter int DEPTH = arcd_pkg::IN_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_record_start,
    output logic                      o_valid,
    output arcd_pkg::t_byte_item      o_item,
    input  wire logic                 i_take
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    arcd_pkg::t_byte_item r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr, n_rd;
    logic [CW-1:0] n_count;
    logic          wr_en, rd_en;
    arcd_pkg::t_byte_item new_item;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    always_comb begin
        new_item.data  = i_data_byte;
        new_item.start = i_record_start;
        new_item.zero  = (i_data_byte == 8'd0);
        new_item.more  = i_data_byte[7];
        n_wr    = wr_en ? ((r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = rd_en ? ((r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= new_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("input queue count above depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/arcd_parse.sv =====
// arcd_parse: back end; walks the record one byte word per cycle while the result queue has room, and builds runs
// depends on arcd_pkg
`default_nettype none

module arcd_parse (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire arcd_pkg::t_byte_item i_item,
    output logic                      o_take,
    input  wire logic                 i_room,
    output logic                      o_push,
    output arcd_pkg::t_result         o_result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_MAGIC_OK, PH_MAGIC_BAD, PH_SIZE, PH_CODE, PH_LIST_MIX,
        PH_REP_MIX, PH_TIME, PH_W_COUNT, PH_W_HDR, PH_W_TIME, PH_W_EMIS,
        PH_W_WEIGHT
    } t_phase;

    t_phase        r_phase, n_phase, e_phase;
    logic [2:0]    r_bidx, n_bidx, e_bidx;
    logic [31:0]   r_acc, n_acc, e_acc;
    logic [5:0]    r_vshift, n_vshift, e_vshift;
    logic [31:0]   r_size, n_size;
    logic [31:0]   r_items, n_items;
    logic [31:0]   r_time, n_time;
    logic [7:0]    r_code, n_code;
    logic [1:0]    r_ver, n_ver;
    logic [31:0]   r_emis, n_emis;
    logic [30:0]   r_fleft, n_fleft;

    logic [7:0]    b;
    logic [31:0]   tb_acc, vi_acc;
    logic [2:0]    bidx_inc, tb_len;
    logic          tb_done, vi_done;
    logic [5:0]    vi_shift;
    logic [7:0]    rep_len, code_dec;
    logic [31:0]   add_inc, items_sum, time_sum;
    logic [30:0]   fleft_dec;
    logic          do_witem;
    logic [31:0]   w_val;
    logic [1:0]    w_fmt;
    arcd_pkg::t_result res;
    logic          res_valid;

    assign o_take = i_valid && i_room;
    assign b      = i_item.data;

    always_comb begin
        // a start byte drops whatever record was in progress
        e_phase  = i_item.start ? PH_MAGIC_OK : r_phase;
        e_bidx   = i_item.start ? 3'd0 : r_bidx;
        e_acc    = i_item.start ? 32'd0 : r_acc;
        e_vshift = i_item.start ? 6'd0 : r_vshift;

        // little-endian fixed fields
        tb_acc   = e_acc | (32'(b) << {e_bidx[1:0], 3'b000});
        bidx_inc = e_bidx + 3'd1;
        tb_len   = (e_phase == PH_W_WEIGHT && r_ver == arcd_pkg::VER_U16) ? 3'd2 : 3'd4;
        tb_done  = (bidx_inc >= tb_len);

        // 7-bit varints, groups past bit 31 ignored
        vi_acc   = e_vshift[5] ? e_acc : (e_acc | (32'(b[6:0]) << e_vshift[4:0]));
        vi_shift = e_vshift[5] ? e_vshift : e_vshift + 6'd7;
        vi_done  = !i_item.more;

        rep_len   = ~r_code + 8'd1;
        code_dec  = r_code - 8'd1;
        fleft_dec = r_fleft - 31'd1;
        add_inc   = (e_phase == PH_REP_MIX) ? 32'(rep_len) : 32'd1;
        items_sum = r_items + add_inc;
        time_sum  = r_time + add_inc;

        n_phase  = r_phase;
        n_bidx   = r_bidx;
        n_acc    = r_acc;
        n_vshift = r_vshift;
        n_size   = r_size;
        n_items  = r_items;
        n_time   = r_time;
        n_code   = r_code;
        n_ver    = r_ver;
        n_emis   = r_emis;
        n_fleft  = r_fleft;
        do_witem = 1'b0;
        w_val    = 32'd0;
        w_fmt    = arcd_pkg::FMT_NONE;
        res       = '0;
        res_valid = 1'b0;

        if (o_take && (i_item.start || r_phase != PH_IDLE)) begin
            n_phase  = e_phase;
            n_bidx   = e_bidx;
            n_acc    = e_acc;
            n_vshift = e_vshift;
            unique case (e_phase)
                PH_MAGIC_OK, PH_MAGIC_BAD: begin
                    if (e_phase == PH_MAGIC_BAD || b != arcd_pkg::magic_byte(e_bidx)) begin
                        n_phase = PH_MAGIC_BAD;
                    end
                    if (e_bidx == 3'd7) begin
                        n_bidx = 3'd0;
                        if (n_phase == PH_MAGIC_BAD) begin
                            n_phase    = PH_IDLE;
                            res.status = arcd_pkg::ST_BAD_MAG;
                            res_valid  = 1'b1;
                        end else begin
                            n_acc    = 32'd0;
                            n_vshift = 6'd0;
                            n_phase  = PH_SIZE;
                        end
                    end else begin
                        n_bidx = bidx_inc;
                    end
                end
                PH_SIZE: begin
                    n_acc  = tb_acc;
                    n_bidx = bidx_inc;
                    if (tb_done) begin
                        n_acc    = 32'd0;
                        n_vshift = 6'd0;
                        n_bidx   = 3'd0;
                        n_items  = 32'd0;
                        n_time   = 32'd0;
                        if (!tb_acc[31]) begin
                            n_size = tb_acc;
                            if (tb_acc == 32'd0) begin
                                n_phase       = PH_IDLE;
                                res.last_item = 1'b1;
                                res.status    = arcd_pkg::ST_EMPTY;
                                res_valid     = 1'b1;
                            end else begin
                                n_phase = PH_CODE;
                            end
                        end else if (tb_acc[30:0] > arcd_pkg::MAX_VERSION) begin
                            n_phase    = PH_IDLE;
                            res.status = arcd_pkg::ST_BAD_VER;
                            res_valid  = 1'b1;
                        end else begin
                            n_ver   = tb_acc[1:0];
                            n_phase = PH_W_COUNT;
                        end
                    end
                end
                PH_CODE: begin
                    n_code   = b;
                    n_acc    = 32'd0;
                    n_vshift = 6'd0;
                    n_bidx   = 3'd0;
                    if (i_item.zero) begin
                        n_phase = PH_TIME;
                    end else if (!b[7]) begin
                        n_phase = PH_LIST_MIX;
                    end else begin
                        n_phase = PH_REP_MIX;
                    end
                end
                PH_TIME: begin
                    n_acc  = tb_acc;
                    n_bidx = bidx_inc;
                    if (tb_done) begin
                        n_time  = tb_acc;
                        n_acc   = 32'd0;
                        n_bidx  = 3'd0;
                        n_phase = PH_CODE;
                    end
                end
                PH_LIST_MIX: begin
                    n_acc  = tb_acc;
                    n_bidx = bidx_inc;
                    if (tb_done) begin
                        n_acc           = 32'd0;
                        n_bidx          = 3'd0;
                        n_emis          = tb_acc;
                        n_items         = items_sum;
                        n_code          = code_dec;
                        n_time          = time_sum;
                        res.start_time  = r_time;
                        res.emission_id = tb_acc;
                        res.run_length  = 7'd1;
                        res.status      = arcd_pkg::ST_ITEM;
                        res_valid       = 1'b1;
                        if (code_dec == 8'd0) begin
                            if (items_sum >= r_size) begin
                                res.last_item = 1'b1;
                                n_phase       = PH_IDLE;
                            end else begin
                                n_phase = PH_CODE;
                            end
                        end
                    end
                end
                PH_REP_MIX: begin
                    n_acc  = tb_acc;
                    n_bidx = bidx_inc;
                    if (tb_done) begin
                        n_acc           = 32'd0;
                        n_bidx          = 3'd0;
                        n_emis          = tb_acc;
                        n_items         = items_sum;
                        n_time          = time_sum;
                        res.start_time  = r_time;
                        res.emission_id = tb_acc;
                        // a run of 128 wraps to zero
                        res.run_length  = rep_len[6:0];
                        res.status      = arcd_pkg::ST_ITEM;
                        res_valid       = 1'b1;
                        if (items_sum >= r_size) begin
                            res.last_item = 1'b1;
                            n_phase       = PH_IDLE;
                        end else begin
                            n_phase = PH_CODE;
                        end
                    end
                end
                PH_W_COUNT: begin
                    n_acc    = vi_acc;
                    n_vshift = vi_shift;
                    if (vi_done) begin
                        n_acc    = 32'd0;
                        n_vshift = 6'd0;
                        n_bidx   = 3'd0;
                        n_size   = vi_acc;
                        if (vi_acc == 32'd0) begin
                            n_phase       = PH_IDLE;
                            res.last_item = 1'b1;
                            res.status    = arcd_pkg::ST_EMPTY;
                            res_valid     = 1'b1;
                        end else begin
                            n_phase = PH_W_HDR;
                        end
                    end
                end
                PH_W_HDR: begin
                    n_acc    = vi_acc;
                    n_vshift = vi_shift;
                    if (vi_done) begin
                        n_acc    = 32'd0;
                        n_vshift = 6'd0;
                        n_bidx   = 3'd0;
                        n_fleft  = vi_acc[31:1];
                        if (vi_acc[0]) begin
                            n_phase = PH_W_TIME;
                        end else if (vi_acc[31:1] == 31'd0) begin
                            // frame with no items only moves time on
                            n_time = time_sum;
                        end else begin
                            n_phase = PH_W_EMIS;
                        end
                    end
                end
                PH_W_TIME: begin
                    n_acc    = vi_acc;
                    n_vshift = vi_shift;
                    if (vi_done) begin
                        n_acc    = 32'd0;
                        n_vshift = 6'd0;
                        n_bidx   = 3'd0;
                        if (r_fleft == 31'd0) begin
                            n_time  = vi_acc + 32'd1;
                            n_phase = PH_W_HDR;
                        end else begin
                            n_time  = vi_acc;
                            n_phase = PH_W_EMIS;
                        end
                    end
                end
                PH_W_EMIS: begin
                    n_acc    = vi_acc;
                    n_vshift = vi_shift;
                    if (vi_done) begin
                        n_acc    = 32'd0;
                        n_vshift = 6'd0;
                        n_bidx   = 3'd0;
                        n_emis   = vi_acc;
                        if (r_ver == arcd_pkg::VER_PLAIN) begin
                            do_witem = 1'b1;
                        end else begin
                            n_phase = PH_W_WEIGHT;
                        end
                    end
                end
                PH_W_WEIGHT: begin
                    n_acc  = tb_acc;
                    n_bidx = bidx_inc;
                    if (tb_done) begin
                        n_acc    = 32'd0;
                        n_vshift = 6'd0;
                        n_bidx   = 3'd0;
                        do_witem = 1'b1;
                        w_val    = tb_acc;
                        w_fmt    = (r_ver == arcd_pkg::VER_U16) ? arcd_pkg::FMT_U16
                                                                 : arcd_pkg::FMT_F32;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (do_witem) begin
                n_items           = items_sum;
                n_fleft           = fleft_dec;
                res.start_time    = r_time;
                res.emission_id   = n_emis;
                res.run_length    = 7'd1;
                res.weight_raw    = w_val;
                res.weight_format = w_fmt;
                res.status        = arcd_pkg::ST_ITEM;
                res_valid         = 1'b1;
                if (fleft_dec == 31'd0) begin
                    n_time = time_sum;
                    if (items_sum >= r_size) begin
                        res.last_item = 1'b1;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_phase = PH_W_HDR;
                    end
                end else begin
                    n_phase = PH_W_EMIS;
                end
            end
        end

        o_push   = res_valid;
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bidx   <= '0;
            r_acc    <= '0;
            r_vshift <= '0;
            r_size   <= '0;
            r_items  <= '0;
            r_time   <= '0;
            r_code   <= '0;
            r_ver    <= '0;
            r_emis   <= '0;
            r_fleft  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_bidx   <= n_bidx;
            r_acc    <= n_acc;
            r_vshift <= n_vshift;
            r_size   <= n_size;
            r_items  <= n_items;
            r_time   <= n_time;
            r_code   <= n_code;
            r_ver    <= n_ver;
            r_emis   <= n_emis;
            r_fleft  <= n_fleft;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (o_result.last_item || o_result.status != arcd_pkg::ST_ITEM))
            |=> (r_phase == PH_IDLE))
        else $error("record end without return to idle");

    a_no_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.weight_format == arcd_pkg::FMT_NONE)
            |-> (o_result.weight_raw == 32'd0))
        else $error("unweighted word carries weight bits");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_take && i_room))
        else $error("result pushed without a consumed byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/arcd_outq.sv =====
// arcd_outq: result queue between the parser and the pop side
// depends on arcd_pkg
`default_nettype none

module arcd_outq #(
    parameter int DEPTH = arcd_pkg::OUT_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire arcd_pkg::t_result i_result,
    output logic                   o_full,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output arcd_pkg::t_result      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    arcd_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr    = wr_en ? ((r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = rd_en ? ((r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_result;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result word pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/alignment_record_decoder_unit.sv =====
// alignment_record_decoder_unit: top level of the alignment record decoder
// depends on arcd_pkg, arcd_front, arcd_parse, arcd_outq
`default_nettype none

// Decodes a serialized alignment record fed one byte per word: the 8-byte magic,
// a little-endian size word, then either run-length codes or the weighted varint
// scheme (versions 0 to 2). Each result word is one run, or a status word for an
// empty record, a bad magic or an unsupported version. Bytes are taken at one per
// clock cycle: the parser retires one byte word each cycle, and each byte adds at
// most one result word, so input, parser and output each run at one word a cycle
// as long as pop keeps up. A byte pushed into an empty input queue reaches the parser
// in the cycle after it is accepted and is consumed once the result queue has room; a
// result word it closes is written into the result queue at the edge that consumes it.
// The parser only advances while the result queue has a free slot. Weights are
// given as raw u16 or f32 bit patterns; a run length of 0 stands for 128.
module alignment_record_decoder_unit #(
    parameter int IN_DEPTH  = arcd_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = arcd_pkg::OUT_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_record_start,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_start_time,
    output logic [31:0]      o_emission_id,
    output logic [6:0]       o_run_length,
    output logic [31:0]      o_weight_raw,
    output logic [1:0]       o_weight_format,
    output logic             o_last_item,
    output logic [1:0]       o_status
);

    logic                  byte_valid, byte_take;
    arcd_pkg::t_byte_item  byte_item;
    logic                  res_push, outq_full;
    arcd_pkg::t_result     res_word, head;

    arcd_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_data_byte    (i_data_byte),
        .i_record_start (i_record_start),
        .o_valid        (byte_valid),
        .o_item         (byte_item),
        .i_take         (byte_take)
    );

    arcd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (byte_valid),
        .i_item   (byte_item),
        .o_take   (byte_take),
        .i_room   (!outq_full),
        .o_push   (res_push),
        .o_result (res_word)
    );

    arcd_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_result (res_word),
        .o_full   (outq_full),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_head   (head)
    );

    assign o_start_time    = head.start_time;
    assign o_emission_id   = head.emission_id;
    assign o_run_length    = head.run_length;
    assign o_weight_raw    = head.weight_raw;
    assign o_weight_format = head.weight_format;
    assign o_last_item     = head.last_item;
    assign o_status        = head.status;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for alignment_record_decoder_unit, byte stream in, run words out
// depends on arcd_pkg and the decoder rtl; records are built here and predicted locally
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TOTAL_BYTES  = 850;

    // ALIGNRLE, first byte in the low bits
    localparam logic [63:0] REC_MAGIC = "ELRNGILA";

    localparam logic [7:0] CODE_TIME = 8'h00;

    typedef enum logic [3:0] {
        PS_IDLE, PS_MAGIC, PS_MAGIC_BAD, PS_SIZE, PS_CODE, PS_LIST, PS_REPEAT, PS_TIME,
        PS_WCOUNT, PS_WHDR, PS_WTIME, PS_WEMIS, PS_WWEIGHT
    } t_parse_state;

    typedef enum {POP_ALWAYS, POP_THREE_IN_FOUR, POP_COIN, POP_STALLS} t_pop_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_stim_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_record_start = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] o_start_time;
    logic [31:0] o_emission_id;
    logic [6:0]  o_run_length;
    logic [31:0] o_weight_raw;
    logic [1:0]  o_weight_format;
    logic        o_last_item;
    logic [1:0]  o_status;

    alignment_record_decoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_record_start (i_record_start),
        .empty          (empty),
        .pop            (pop),
        .o_start_time   (o_start_time),
        .o_emission_id  (o_emission_id),
        .o_run_length   (o_run_length),
        .o_weight_raw   (o_weight_raw),
        .o_weight_format(o_weight_format),
        .o_last_item    (o_last_item),
        .o_status       (o_status)
    );

    always #10 i_clk = ~i_clk;

    t_stim_byte        rec_q[$];
    t_stim_byte        stream_q[$];
    arcd_pkg::t_result pending_runs[$];
    arcd_pkg::t_result run_want;
    int         n_queued = 0;
    int         n_accepted = 0;
    int         n_errors = 0;
    int         cycles = 0;

    // predictor state
    t_parse_state ps = PS_IDLE;
    logic [2:0]   fld_idx = '0;
    logic [31:0]  fld_acc = '0;
    int           vshift = 0;
    logic [31:0]  rec_size = '0;
    logic [31:0]  rec_count = '0;
    logic [31:0]  frame_time = '0;
    logic [7:0]   code_byte = '0;
    logic [1:0]   wt_ver = '0;
    logic [31:0]  cur_emis = '0;
    logic [30:0]  frame_left = '0;

    function automatic bit coin(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic void expect_run(input logic [31:0] t, input logic [31:0] e,
                                       input logic [31:0] len, input logic [31:0] w,
                                       input logic [1:0] fmt, input logic last,
                                       input logic [1:0] st);
        arcd_pkg::t_result r;
        r.start_time    = t;
        r.emission_id   = e;
        r.run_length    = len[6:0];
        r.weight_raw    = w;
        r.weight_format = fmt;
        r.last_item     = last;
        r.status        = st;
        pending_runs.insert(pending_runs.size(), r);
    endfunction

    function automatic logic [31:0] take_acc();
        logic [31:0] v;
        v = fld_acc;
        fld_acc = '0;
        vshift = 0;
        fld_idx = '0;
        return v;
    endfunction

    // little-endian field, true once the n-th byte is in
    function automatic bit take_fixed(input logic [7:0] b, input int n);
        fld_acc = fld_acc | ({24'd0, b} << (8 * fld_idx[1:0]));
        fld_idx = fld_idx + 3'd1;
        if (fld_idx >= n) begin
            fld_idx = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // bits past 31 fall off, the group still counts
    function automatic bit take_varint(input logic [7:0] b);
        if (vshift < 32) begin
            fld_acc = fld_acc | ({25'd0, b[6:0]} << vshift);
            vshift += 7;
        end
        return !b[7];
    endfunction

    function automatic void close_weighted(input logic [31:0] w, input logic [1:0] fmt);
        logic last;
        last = 1'b0;
        rec_count += 1;
        frame_left = frame_left - 31'd1;
        if (frame_left == 0) begin
            if (rec_count >= rec_size) begin
                last = 1'b1;
                ps = PS_IDLE;
            end else begin
                ps = PS_WHDR;
            end
        end else begin
            ps = PS_WEMIS;
        end
        expect_run(frame_time, cur_emis, 32'd1, w, fmt, last, arcd_pkg::ST_ITEM);
        if (frame_left == 0)
            frame_time += 1;
    endfunction

    task automatic decode_record_byte(input logic [7:0] b, input logic st);
        logic [31:0] v;
        logic [31:0] len;
        logic        last;
        last = 1'b0;
        if (st) begin
            v = take_acc();
            ps = PS_MAGIC;
        end else if (ps == PS_IDLE) begin
            return;
        end
        case (ps)
            PS_MAGIC, PS_MAGIC_BAD: begin
                if (b != REC_MAGIC[8 * fld_idx +: 8])
                    ps = PS_MAGIC_BAD;
                if (fld_idx == 3'd7) begin
                    fld_idx = '0;
                    if (ps == PS_MAGIC_BAD) begin
                        ps = PS_IDLE;
                        expect_run('0, '0, '0, '0, arcd_pkg::FMT_NONE, 1'b0,
                                   arcd_pkg::ST_BAD_MAG);
                    end else begin
                        v = take_acc();
                        ps = PS_SIZE;
                    end
                end else begin
                    fld_idx = fld_idx + 3'd1;
                end
            end
            PS_SIZE: begin
                if (take_fixed(b, 4)) begin
                    v = take_acc();
                    rec_count = '0;
                    frame_time = '0;
                    if (!v[31]) begin
                        rec_size = v;
                        if (v == 0) begin
                            ps = PS_IDLE;
                            expect_run('0, '0, '0, '0, arcd_pkg::FMT_NONE, 1'b1,
                                       arcd_pkg::ST_EMPTY);
                        end else begin
                            ps = PS_CODE;
                        end
                    end else if (v[30:0] > 31'(arcd_pkg::VER_F32)) begin
                        ps = PS_IDLE;
                        expect_run('0, '0, '0, '0, arcd_pkg::FMT_NONE, 1'b0,
                                   arcd_pkg::ST_BAD_VER);
                    end else begin
                        wt_ver = v[1:0];
                        ps = PS_WCOUNT;
                    end
                end
            end
            PS_CODE: begin
                code_byte = b;
                v = take_acc();
                if (b == CODE_TIME)
                    ps = PS_TIME;
                else if (!b[7])
                    ps = PS_LIST;
                else
                    ps = PS_REPEAT;
            end
            PS_TIME: begin
                if (take_fixed(b, 4)) begin
                    frame_time = take_acc();
                    ps = PS_CODE;
                end
            end
            PS_LIST: begin
                if (take_fixed(b, 4)) begin
                    cur_emis = take_acc();
                    rec_count += 1;
                    code_byte = code_byte - 8'd1;
                    if (code_byte == 0) begin
                        if (rec_count >= rec_size) begin
                            last = 1'b1;
                            ps = PS_IDLE;
                        end else begin
                            ps = PS_CODE;
                        end
                    end
                    expect_run(frame_time, cur_emis, 32'd1, '0, arcd_pkg::FMT_NONE, last,
                               arcd_pkg::ST_ITEM);
                    frame_time += 1;
                end
            end
            PS_REPEAT: begin
                if (take_fixed(b, 4)) begin
                    cur_emis = take_acc();
                    len = 32'd256 - code_byte;
                    rec_count += len;
                    if (rec_count >= rec_size) begin
                        last = 1'b1;
                        ps = PS_IDLE;
                    end else begin
                        ps = PS_CODE;
                    end
                    expect_run(frame_time, cur_emis, len, '0, arcd_pkg::FMT_NONE, last,
                               arcd_pkg::ST_ITEM);
                    frame_time += len;
                end
            end
            PS_WCOUNT: begin
                if (take_varint(b)) begin
                    rec_size = take_acc();
                    if (rec_size == 0) begin
                        ps = PS_IDLE;
                        expect_run('0, '0, '0, '0, arcd_pkg::FMT_NONE, 1'b1,
                                   arcd_pkg::ST_EMPTY);
                    end else begin
                        ps = PS_WHDR;
                    end
                end
            end
            PS_WHDR: begin
                if (take_varint(b)) begin
                    v = take_acc();
                    frame_left = v[31:1];
                    if (v[0])
                        ps = PS_WTIME;
                    else if (frame_left == 0)
                        frame_time += 1;
                    else
                        ps = PS_WEMIS;
                end
            end
            PS_WTIME: begin
                if (take_varint(b)) begin
                    frame_time = take_acc();
                    if (frame_left == 0) begin
                        frame_time += 1;
                        ps = PS_WHDR;
                    end else begin
                        ps = PS_WEMIS;
                    end
                end
            end
            PS_WEMIS: begin
                if (take_varint(b)) begin
                    cur_emis = take_acc();
                    if (wt_ver == arcd_pkg::VER_PLAIN)
                        close_weighted('0, arcd_pkg::FMT_NONE);
                    else
                        ps = PS_WWEIGHT;
                end
            end
            PS_WWEIGHT: begin
                if (wt_ver == arcd_pkg::VER_U16) begin
                    if (take_fixed(b, 2))
                        close_weighted(take_acc(), arcd_pkg::FMT_U16);
                end else if (take_fixed(b, 4)) begin
                    close_weighted(take_acc(), arcd_pkg::FMT_F32);
                end
            end
            default: ps = PS_IDLE;
        endcase
    endtask

    // record building
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic st = 1'b0);
        t_stim_byte w;
        w.data = b;
        w.start = st;
        rec_q.insert(rec_q.size(), w);
    endtask

    task automatic add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            add_byte(v[8 * i +: 8]);
    endtask

    // stretched form runs past bit 31 with junk in the dropped bits
    task automatic add_varint(input logic [31:0] v, input bit stretch);
        int extra;
        if (stretch) begin
            for (int i = 0; i < 4; i++)
                add_byte({1'b1, v[7 * i +: 7]});
            add_byte({1'b1, 3'($urandom), v[31:28]});
            extra = $urandom_range(0, 2);
            repeat (extra) add_byte({1'b1, 7'($urandom)});
            add_byte({1'b0, 7'($urandom)});
        end else begin
            while (v > 127) begin
                add_byte({1'b1, v[6:0]});
                v = v >> 7;
            end
            add_byte({1'b0, v[6:0]});
        end
    endtask

    // bad_at outside 0..7 gives a clean magic
    task automatic add_magic(input int bad_at);
        for (int i = 0; i < 8; i++)
            add_byte(REC_MAGIC[8 * i +: 8] ^ ((i == bad_at) ? 8'($urandom_range(1, 255)) : 8'h00),
                     i == 0);
    endtask

    task automatic build_rle(input logic [31:0] size);
        logic [31:0] cnt;
        int          n;
        add_magic(8);
        add_le(size, 4);
        cnt = '0;
        while (cnt < size) begin
            case ($urandom_range(0, 5))
                0: begin
                    add_byte(CODE_TIME);
                    add_le(pick_word(), 4);
                end
                1, 2, 3: begin
                    n = $urandom_range(1, 6);
                    add_byte(8'(n));
                    repeat (n) add_le(pick_word(), 4);
                    cnt += n;
                end
                default: begin
                    n = coin(2) ? $urandom_range(1, 8) : $urandom_range(1, 128);
                    add_byte(8'(256 - n));
                    add_le(pick_word(), 4);
                    cnt += n;
                end
            endcase
        end
    endtask

    task automatic build_weighted(input logic [1:0] ver, input logic [31:0] count);
        logic [31:0] cnt;
        int          k;
        bit          odd;
        add_magic(8);
        add_le({1'b1, 29'd0, ver}, 4);
        add_varint(count, coin(8));
        cnt = '0;
        while (cnt < count) begin
            k = coin(5) ? 0 : $urandom_range(1, 4);
            odd = coin(2);
            add_varint((32'(k) << 1) | 32'(odd), coin(8));
            if (odd)
                add_varint(pick_word(), coin(8));
            repeat (k) begin
                add_varint(pick_word(), coin(8));
                if (ver == arcd_pkg::VER_U16)
                    add_le(32'($urandom_range(0, 65535)), 2);
                else if (ver == arcd_pkg::VER_F32)
                    add_le(pick_word(), 4);
            end
            cnt += k;
        end
    endtask

    // hand the built bytes to the driver, optionally only a leading part
    task automatic commit_record(input bit cut);
        int keep;
        keep = rec_q.size();
        if (cut && keep > 1)
            keep = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++) begin
            stream_q.insert(stream_q.size(), rec_q[i]);
            n_queued++;
        end
        rec_q.delete();
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || pending_runs.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored bytes, bad magic on the last and on the first byte
        repeat (3) add_byte(8'($urandom));
        add_magic(7);
        add_magic(0);
        // empty record and unsupported versions
        add_magic(8);
        add_le(32'd0, 4);
        add_magic(8);
        add_le(32'h8000_0003, 4);
        add_magic(8);
        add_le(32'hFFFF_FFFF, 4);
        // time jump to the wrap point, run of one, literals, run of 128 overshooting
        add_magic(8);
        add_le(32'd4, 4);
        add_byte(CODE_TIME);
        add_le(32'hFFFF_FFFE, 4);
        add_byte(8'hFF);
        add_le(32'hFFFF_FFFF, 4);
        add_byte(8'h02);
        add_le(32'd0, 4);
        add_le(32'h8000_0001, 4);
        add_byte(8'h80);
        add_le(32'h1234_5678, 4);
        // literal list of 127 against a size of one
        add_magic(8);
        add_le(32'd1, 4);
        add_byte(8'h7F);
        repeat (127) add_le(pick_word(), 4);
        // largest size, dropped by the next record start
        add_magic(8);
        add_le(32'h7FFF_FFFF, 4);
        add_byte(8'h81);
        add_le(32'd7, 4);
        // weighted, zero count in a stretched varint
        add_magic(8);
        add_le(32'h8000_0000, 4);
        add_varint(32'd0, 1'b1);
        // u16: time set to the wrap point, empty frame, then two items
        add_magic(8);
        add_le({1'b1, 29'd0, arcd_pkg::VER_U16}, 4);
        add_varint(32'd2, 1'b0);
        add_varint(32'd1, 1'b0);
        add_varint(32'hFFFF_FFFF, 1'b0);
        add_varint(32'd0, 1'b0);
        add_varint(32'd4, 1'b0);
        add_varint(32'd0, 1'b0);
        add_le(32'h0000_FFFF, 2);
        add_varint(32'hFFFF_FFFF, 1'b1);
        add_le(32'd0, 2);
        // f32: timed frame with one item, stretched varints
        add_magic(8);
        add_le({1'b1, 29'd0, arcd_pkg::VER_F32}, 4);
        add_varint(32'd1, 1'b0);
        add_varint(32'd3, 1'b1);
        add_varint(32'h8000_0000, 1'b1);
        add_varint(32'd5, 1'b0);
        add_le(32'hFFFF_FFFF, 4);
        build_weighted(arcd_pkg::VER_PLAIN, 32'd4);
        commit_record(1'b0);
        // restart in the middle of a record
        build_rle(32'd5);
        commit_record(1'b1);
        wait_drained();

        while (n_queued < TOTAL_BYTES) begin
            case ($urandom_range(0, 19))
                0: repeat ($urandom_range(1, 6)) add_byte(8'($urandom), coin(6));
                1: add_magic($urandom_range(0, 7));
                2: begin
                    add_magic(8);
                    add_le({1'b1, coin(4) ? 31'h7FFF_FFFF : 31'($urandom_range(3, 1000))}, 4);
                end
                3: begin
                    add_magic(8);
                    if (coin(2)) begin
                        add_le(32'd0, 4);
                    end else begin
                        add_le({1'b1, 29'd0, 2'($urandom_range(0, 2))}, 4);
                        add_varint(32'd0, coin(4));
                    end
                end
                4, 5, 6, 7, 8, 9, 10: build_rle($urandom_range(1, 12));
                default: build_weighted(2'($urandom_range(0, 2)), $urandom_range(1, 8));
            endcase
            commit_record(coin(12));
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // sender: bursts of bytes with random gaps
    int burst_left = 0;
    int gap_left = 0;
    t_stim_byte next_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                decode_record_byte(i_data_byte, i_record_start);
                n_accepted++;
            end
            if (!push || !full) begin
                if (gap_left > 0 || stream_q.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    push <= 1'b0;
                end else begin
                    next_word = stream_q.pop_front();
                    push <= 1'b1;
                    i_data_byte <= next_word.data;
                    i_record_start <= next_word.start;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = coin(3) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // receiver: stall pattern, picked at random from four modes, changes during the run
    t_pop_mode pop_mode = POP_ALWAYS;
    int        pop_tick = 0;
    int        stall_left = 0;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_runs.size() == 0) begin
                    $error("unexpected word: status %0d emission %0h", o_status, o_emission_id);
                    n_errors++;
                end else begin
                    run_want = pending_runs.pop_front();
                    check_field("start_time", run_want.start_time, o_start_time);
                    check_field("emission_id", run_want.emission_id, o_emission_id);
                    check_field("run_length", 32'(run_want.run_length), 32'(o_run_length));
                    check_field("weight_raw", run_want.weight_raw, o_weight_raw);
                    check_field("weight_format", 32'(run_want.weight_format),
                                32'(o_weight_format));
                    check_field("last_item", 32'(run_want.last_item), 32'(o_last_item));
                    check_field("status", 32'(run_want.status), 32'(o_status));
                end
            end
            pop_tick++;
            if (pop_tick % 200 == 0)
                pop_mode = t_pop_mode'($urandom_range(0, 3));
            case (pop_mode)
                POP_ALWAYS: pop <= 1'b1;
                POP_THREE_IN_FOUR: pop <= (pop_tick % 4) != 0;
                POP_COIN: pop <= 1'($urandom);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        pop <= 1'b0;
                    end else begin
                        pop <= 1'b1;
                        if (coin(8))
                            stall_left = $urandom_range(3, 12);
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
